>>> hw/rtl/ilst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_pkg: shared types and constants for the indexed list store
// Operation codes, status codes, field widths and the command that the
// decoder broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package ilst_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET  = 3'd0,
    FUNC_HEAD = 3'd1,
    FUNC_TAIL = 3'd2,
    FUNC_AT   = 3'd3,
    FUNC_DEL  = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Command broadcast along the chain
  typedef struct packed {
    logic ins;   // open a gap at the target and write the new value there
    logic del;   // close the gap at the target
    logic get;   // target cell drives its value onto the read bus
    logic miss;  // get found no entry
  } cmd_t;

endpackage

>>> hw/rtl/ilst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_cell: one storage cell of the list chain
// Holds one entry. On insert, past the target it takes its left neighbor (the
// new value at the target); on delete, from it on, the right; else it holds.
// ----------------------------------------------------------------------------
module ilst_cell #(
  parameter int INDEX = 0,
  parameter int CMP_W = 7
) (
  input  logic                       clk,
  input  ilst_pkg::cmd_t             cmd,
  input  logic [CMP_W-1:0]           tgt,
  input  logic [ilst_pkg::DATA_W-1:0] value_in,
  input  logic [ilst_pkg::DATA_W-1:0] left_value,
  input  logic [ilst_pkg::DATA_W-1:0] right_value,
  output logic [ilst_pkg::DATA_W-1:0] value,
  output logic [ilst_pkg::DATA_W-1:0] sel_value
);
  import ilst_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic at_tgt;
  logic past_tgt;
  logic [DATA_W-1:0] value_next;

  assign at_tgt   = (MY_IDX == tgt);
  assign past_tgt = (MY_IDX > tgt);

  // Pick the next entry: shift right on insert, shift left on delete
  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (at_tgt) begin
        value_next = value_in;
      end else if (past_tgt) begin
        value_next = left_value;
      end
    end else if (cmd.del) begin
      if (at_tgt || past_tgt) begin
        value_next = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Drive the read bus only when this cell is addressed by a get
  assign sel_value = (cmd.get && at_tgt) ? value : '0;

endmodule

>>> hw/rtl/ilst_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_decode: operation decoder for the indexed list store
// Checks the position against the entry count and the capacity, and forms
// the chain command, its target index, the status and the next count.
// ----------------------------------------------------------------------------
module ilst_decode #(
  parameter int CAPACITY = ilst_pkg::CAPACITY_DEF,
  parameter int CNT_W    = 7,
  parameter int CMP_W    = 7
) (
  input  logic [ilst_pkg::FUNC_W-1:0] func,
  input  logic [ilst_pkg::POS_W-1:0]  position,
  input  logic [CNT_W-1:0]            count,
  output ilst_pkg::cmd_t              cmd,
  output logic [CMP_W-1:0]            tgt,
  output ilst_pkg::status_t           status,
  output logic [CNT_W-1:0]            count_next
);
  import ilst_pkg::*;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;

  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);
  assign full  = (cnt_x == CMP_W'(CAPACITY));

  // Decode the operation against the current fill level
  always_comb begin
    cmd    = '0;
    tgt    = pos_x;
    status = STATUS_DONE;
    case (func)
      FUNC_GET: begin
        if (pos_x < cnt_x) begin
          cmd.get = 1'b1;
        end else begin
          cmd.miss = 1'b1;
          status   = STATUS_RANGE;
        end
      end
      FUNC_HEAD: begin
        tgt = '0;
        if (full) begin
          status = STATUS_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      FUNC_TAIL: begin
        tgt = cnt_x;
        if (full) begin
          status = STATUS_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      FUNC_AT: begin
        if (pos_x > cnt_x) begin
          status = STATUS_RANGE;
        end else if (full) begin
          status = STATUS_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      FUNC_DEL: begin
        if (pos_x < cnt_x) begin
          cmd.del = 1'b1;
        end else begin
          status = STATUS_RANGE;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Advance the entry count
  always_comb begin
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.del) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

endmodule

>>> hw/rtl/indexed_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of signed 32-bit values in a cell chain
// The result of an item is registered, valid in the cycle after its accept.
// Throughput: one item per cycle while the output is not stalled.
// An item is taken in the same cycle as the previous result, so a stalled
// output holds off the input for as long as the stall lasts.
// Reset clears the entry count and the output valid; cell contents are left
// as they are and never show before they are written.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ilst_pkg::FUNC_W-1:0]         func,
  input  logic [ilst_pkg::POS_W-1:0]          position,
  input  logic signed [ilst_pkg::DATA_W-1:0]  value_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ilst_pkg::DATA_W-1:0]  read_value,
  output logic                                hit,
  output logic [ilst_pkg::STATUS_W-1:0]       status,
  output logic [ilst_pkg::LEN_W-1:0]          length
);
  import ilst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic              accept;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  cmd_t              cmd;
  cmd_t              cmd_go;
  logic [CMP_W-1:0]  tgt;
  status_t           dec_status;
  logic [DATA_W-1:0] cell_value [CAPACITY];
  logic [DATA_W-1:0] cell_sel   [CAPACITY];
  logic [DATA_W-1:0] sel_bus;
  logic [DATA_W-1:0] rd_next;

  // Take an item unless a finished result is held by the stall
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  ilst_decode #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .CMP_W    (CMP_W)
  ) u_decode (
    .func       (func),
    .position   (position),
    .count      (count),
    .cmd        (cmd),
    .tgt        (tgt),
    .status     (dec_status),
    .count_next (count_next)
  );

  // Only an accepted item moves the chain
  assign cmd_go = accept ? cmd : '0;

  // Row of cells, each fed by its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_value[i+1];
    end

    ilst_cell #(
      .INDEX (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd_go),
      .tgt         (tgt),
      .value_in    (value_in),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .sel_value   (cell_sel[i])
    );
  end

  // Merge the one-hot read bus
  always_comb begin
    sel_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_bus = sel_bus | cell_sel[k];
    end
  end

  // Form the read value: entry on hit, all ones on miss, zero otherwise
  always_comb begin
    if (cmd.get) begin
      rd_next = sel_bus;
    end else if (cmd.miss) begin
      rd_next = '1;
    end else begin
      rd_next = '0;
    end
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_next;
      hit        <= cmd.get;
      status     <= dec_status;
      length     <= LEN_W'(count_next);
    end
  end

endmodule
